>>> sv/fcfs_tick_scheduler_top_macros.svh
// Assertion macros for the tick scheduler.
// Used by the modules that carry concurrent checks; no other dependencies.
`ifndef FCFS_TICK_SCHEDULER_TOP_MACROS_SVH
`define FCFS_TICK_SCHEDULER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FTS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define FTS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> sv/fts_pkg.sv
// Shared types and constants for the tick scheduler.
// No dependencies; imported by every module of the block.
package fts_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int SUM_W           = 48;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	localparam logic ACT_ARRIVE = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	localparam logic STAT_DONE = 1'b0;
	localparam logic STAT_DROP = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HEAD,
		S_SUM,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic        action;
		logic [7:0]  process_id;
		logic [15:0] burst_time;
	} in_t;

	typedef struct packed {
		logic             status;
		logic [7:0]       job_id;
		logic [31:0]      turnaround;
		logic [31:0]      waiting;
		logic [SUM_W-1:0] total_turnaround;
		logic [SUM_W-1:0] total_waiting;
		logic [31:0]      completed_count;
	} out_t;

	typedef struct packed {
		logic [7:0]  job_id;
		logic [31:0] arrival;
		logic [15:0] burst;
	} entry_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

endpackage

>>> sv/fcfs_tick_scheduler_top.sv
// First-come-first-served tick scheduler: a job queue held in a synchronous
// memory, one request at a time. An arrive request or a tick on an empty queue
// is handled when it is accepted; a tick that does not finish the head job
// first reads the head entry through the registered memory read; a tick that
// finishes a job goes through head read, timing, running totals and hand-over
// to the output register, and a dropped arrival goes straight to hand-over.
// Results wait in an output register, so a new request is taken while an
// earlier result is still stalled. No clearing pass is needed after reset.
// Depends on fts_pkg, fts_core and fts_qmem.
module fcfs_tick_scheduler_top #(
	parameter int QUEUE_DEPTH = fts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  fts_pkg::in_t  item,
	output logic          result_valid,
	input  logic          result_stall,
	output fts_pkg::out_t result
);
	import fts_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int OW = $clog2(QUEUE_DEPTH + 1);

	mem_ctl_t      mem_ctl;
	logic [AW-1:0] waddr, raddr;
	entry_t        wdata, rdata;
	logic          res_valid, res_taken;
	out_t          res;
	logic          out_valid_q;
	out_t          out_q;

	fts_qmem #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_qmem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	fts_core #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW),
		.OW    (OW)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.mem_ctl    (mem_ctl),
		.waddr      (waddr),
		.raddr      (raddr),
		.wdata      (wdata),
		.rdata      (rdata),
		.res_valid  (res_valid),
		.res        (res),
		.res_taken  (res_taken)
	);

	// slot is free when empty or being drained this cycle
	assign res_taken = res_valid && (!out_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_taken) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_taken) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

>>> sv/fts_qmem.sv
// Job queue storage: one write port, one registered read port.
// Depends on fts_pkg for the entry layout.
module fts_qmem #(
	parameter int DEPTH = fts_pkg::QUEUE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  fts_pkg::mem_ctl_t ctl,
	input  logic [AW-1:0]     waddr,
	input  fts_pkg::entry_t   wdata,
	input  logic [AW-1:0]     raddr,
	output fts_pkg::entry_t   rdata
);
	import fts_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/fts_core.sv
// Scheduler sequencer: queue pointers, clock, service count and running totals.
// Depends on fts_pkg and the assertion macro header; drives fts_qmem.
`include "fcfs_tick_scheduler_top_macros.svh"
module fts_core #(
	parameter int DEPTH = fts_pkg::QUEUE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int OW    = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  fts_pkg::in_t      item,
	output logic              item_stall,
	output fts_pkg::mem_ctl_t mem_ctl,
	output logic [AW-1:0]     waddr,
	output logic [AW-1:0]     raddr,
	output fts_pkg::entry_t   wdata,
	input  fts_pkg::entry_t   rdata,
	output logic              res_valid,
	output fts_pkg::out_t     res,
	input  logic              res_taken
);
	import fts_pkg::*;

	state_t           state_q, state_d;
	logic [31:0]      time_q;
	logic [15:0]      sd_q;
	logic [AW-1:0]    rp_q, wp_q;
	logic [OW-1:0]    occ_q;
	logic [SUM_W-1:0] sum_tat_q, sum_wt_q;
	logic [31:0]      fin_q;
	out_t             res_q;

	logic             accept;
	logic             is_full;
	logic [16:0]      served;
	logic             head_done;
	logic [SUM_W:0]   tat_add, wt_add;
	logic [SUM_W-1:0] tat_sat, wt_sat;

	assign accept    = item_valid && (state_q == S_IDLE);
	assign is_full   = (occ_q == OW'(DEPTH));
	assign served    = {1'b0, sd_q} + 17'd1;
	assign head_done = (served >= {1'b0, rdata.burst});

	// acc never exceeds the max, so a carry out is the only overflow
	assign tat_add = {1'b0, sum_tat_q} + {{(SUM_W-31){1'b0}}, res_q.turnaround};
	assign wt_add  = {1'b0, sum_wt_q} + {{(SUM_W-31){1'b0}}, res_q.waiting};
	assign tat_sat = tat_add[SUM_W] ? SUM_MAX : tat_add[SUM_W-1:0];
	assign wt_sat  = wt_add[SUM_W] ? SUM_MAX : wt_add[SUM_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (item.action == ACT_ARRIVE) begin
						if (is_full) state_d = S_EMIT;
					end else if (occ_q != '0) begin
						state_d = S_HEAD;
					end
				end
			end
			S_HEAD: begin
				state_d = head_done ? S_SUM : S_IDLE;
			end
			S_SUM: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (res_taken) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		item_stall    = (state_q != S_IDLE);
		res_valid     = (state_q == S_EMIT);
		mem_ctl.wr_en = accept && (item.action == ACT_ARRIVE) && !is_full;
		mem_ctl.rd_en = accept && (item.action == ACT_TICK) && (occ_q != '0);
		waddr         = wp_q;
		raddr         = rp_q;
		wdata.job_id  = item.process_id;
		wdata.arrival = time_q;
		wdata.burst   = item.burst_time;
		res           = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			time_q    <= '0;
			sd_q      <= '0;
			rp_q      <= '0;
			wp_q      <= '0;
			occ_q     <= '0;
			sum_tat_q <= '0;
			sum_wt_q  <= '0;
			fin_q     <= '0;
		end else begin
			state_q <= state_d;
			if (mem_ctl.wr_en) begin
				wp_q  <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
				occ_q <= occ_q + 1'b1;
			end
			if (accept && (item.action == ACT_TICK)) begin
				time_q <= time_q + 32'd1;
			end
			if (state_q == S_HEAD) begin
				if (head_done) begin
					sd_q  <= '0;
					rp_q  <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
					occ_q <= occ_q - 1'b1;
				end else begin
					sd_q <= served[15:0];
				end
			end
			if (state_q == S_SUM) begin
				sum_tat_q <= tat_sat;
				sum_wt_q  <= wt_sat;
				fin_q     <= fin_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (item.action == ACT_ARRIVE) && is_full) begin
			res_q.status           <= STAT_DROP;
			res_q.job_id           <= item.process_id;
			res_q.turnaround       <= '0;
			res_q.waiting          <= '0;
			res_q.total_turnaround <= sum_tat_q;
			res_q.total_waiting    <= sum_wt_q;
			res_q.completed_count  <= fin_q;
		end else if ((state_q == S_HEAD) && head_done) begin
			// time_q already counts this tick
			res_q.status     <= STAT_DONE;
			res_q.job_id     <= rdata.job_id;
			res_q.turnaround <= time_q - rdata.arrival;
			res_q.waiting    <= time_q - rdata.arrival - {16'd0, rdata.burst};
		end else if (state_q == S_SUM) begin
			res_q.total_turnaround <= tat_sat;
			res_q.total_waiting    <= wt_sat;
			res_q.completed_count  <= fin_q + 32'd1;
		end
	end

	`FTS_ASSERT(a_occ_bound, clk, arst_n, occ_q <= OW'(DEPTH), "queue occupancy above depth")
	`FTS_ASSERT(a_head_nonempty, clk, arst_n, (state_q == S_HEAD) |-> (occ_q != '0), "head read on empty queue")
	`FTS_ASSERT(a_pop_count, clk, arst_n, ((state_q == S_HEAD) && head_done) |=> (occ_q == $past(occ_q) - 1'b1), "completion did not pop")
	`FTS_ASSERT(a_tick_time, clk, arst_n, (accept && (item.action == ACT_TICK)) |=> (time_q == $past(time_q) + 32'd1), "tick did not advance clock")
	`FTS_ASSERT(a_ptr_range, clk, arst_n, (rp_q <= AW'(DEPTH - 1)) && (wp_q <= AW'(DEPTH - 1)), "queue pointer out of range")

endmodule
